### design/fcqd_pkg.sv
// Shared types and constants for the frame check and query de-duplication block.
`default_nettype none

package fcqd_pkg;

    localparam logic [7:0] HEAD_MARK      = 8'h68;
    localparam logic [7:0] TAIL_MARK      = 8'h16;
    localparam logic [7:0] DIR_BIT        = 8'h80;
    localparam logic [7:0] ASK_FUNC       = 8'h01;
    localparam int         FRAME_OVERHEAD = 6;
    localparam int         MIN_ASK_LEN    = 5;

    localparam logic [3:0] ST_TOO_SHORT    = 4'd0;
    localparam logic [3:0] ST_BAD_HEAD     = 4'd1;
    localparam logic [3:0] ST_BAD_LENGTH   = 4'd2;
    localparam logic [3:0] ST_BAD_TAIL     = 4'd3;
    localparam logic [3:0] ST_BAD_CHECKSUM = 4'd4;
    localparam logic [3:0] ST_REPLY_DIR    = 4'd5;
    localparam logic [3:0] ST_UNKNOWN_FUNC = 4'd6;
    localparam logic [3:0] ST_DUP_OR_SHORT = 4'd7;
    localparam logic [3:0] ST_NEW_ASK      = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } in_beat_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  func_code;
        logic [31:0] time_tag;
    } out_beat_t;

    // Verdict from the parser; ask_full marks a well-formed ask-IP request
    // whose tag still has to be checked against the stored one.
    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  func_code;
        logic [31:0] time_tag;
        logic        ask_full;
    } fcqd_verdict_t;

endpackage

`default_nettype wire

### design/frame_check_and_query_dedup.sv
// Top level: input register, frame parser, tag de-duplication and result register.
// A beat waits in the input register; its result is held in the result register.
// One byte beat per cycle, unless a final beat meets a stalled result register.
// Only a beat flagged frame_end produces a result beat; other beats produce none.
// Reset (aresetn low, synchronous) empties both registers, clears the frame state
// and sets the stored time tag to zero.
`default_nettype none

module frame_check_and_query_dedup #(
    parameter int MAX_FRAME_LEN = 1024
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  fcqd_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output fcqd_pkg::out_beat_t  m_data
);
    import fcqd_pkg::*;

    // Input register.
    logic          in_valid_reg;
    in_beat_t      in_beat_reg;

    // Result register.
    logic          m_valid_reg;
    out_beat_t     m_data_reg, m_data_next;

    // Last tag seen in a new ask-IP request.
    logic [31:0]   stored_tag_reg, stored_tag_next;

    fcqd_verdict_t verdict;
    logic          advance;
    logic          emit;

    // A non-final beat never touches the result side, so it may always advance;
    // a final beat waits for the result register to be free or draining.
    assign advance = in_valid_reg && (!in_beat_reg.frame_end || !m_valid_reg || m_ready);
    assign emit    = advance && in_beat_reg.frame_end;
    assign s_ready = !in_valid_reg || advance;

    fcqd_parser #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .beat    (in_beat_reg),
        .verdict (verdict)
    );

    // Resolve duplicate against new for a complete ask-IP request.
    always_comb begin
        m_data_next.status    = verdict.status;
        m_data_next.func_code = verdict.func_code;
        m_data_next.time_tag  = verdict.time_tag;
        stored_tag_next       = stored_tag_reg;
        if (verdict.ask_full) begin
            if (verdict.time_tag == stored_tag_reg) begin
                m_data_next.status = ST_DUP_OR_SHORT;
            end else begin
                m_data_next.status = ST_NEW_ASK;
                stored_tag_next    = verdict.time_tag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Load a new beat whenever the register is free or moving on.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_beat_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            stored_tag_reg <= '0;
        end else if (emit) begin
            m_valid_reg    <= 1'b1;
            stored_tag_reg <= stored_tag_next;
        end else if (m_ready) begin
            m_valid_reg    <= 1'b0;
        end
    end

    // Hold the result until taken; the free-or-draining rule in advance guards it.
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A new ask must leave its tag stored.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && m_data_next.status == ST_NEW_ASK) |=> stored_tag_reg == m_data_reg.time_tag)
        else $error("stored tag does not follow a new ask");

    // The tag is only reported for a checked ask-IP request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status != ST_DUP_OR_SHORT
            && m_data_reg.status != ST_NEW_ASK) |-> m_data_reg.time_tag == 32'd0)
        else $error("time tag reported outside an ask result");

    // A pending final beat must not overwrite an untaken result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && in_valid_reg && in_beat_reg.frame_end) |-> !advance)
        else $error("result register overwritten while stalled");

    // The stored tag only changes on the beat that reports a new ask.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!$stable(stored_tag_reg) && $past(aresetn)) |-> (m_valid_reg
            && m_data_reg.status == ST_NEW_ASK))
        else $error("stored tag changed without a new ask");

endmodule

`default_nettype wire

### design/fcqd_parser.sv
// Per-frame byte parser: header capture, running checksum and verdict logic.
`default_nettype none

module fcqd_parser #(
    parameter int MAX_FRAME_LEN = 1024
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    step,
    input  fcqd_pkg::in_beat_t     beat,
    output fcqd_pkg::fcqd_verdict_t verdict
);
    import fcqd_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_LEN + 2);
    localparam int LEN_W = (CNT_W + 1 > 16) ? CNT_W + 1 : 16;

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       head_first_reg, head_first_next;
    logic [7:0]       head_second_reg, head_second_next;
    logic [15:0]      declared_len_reg, declared_len_next;
    logic [7:0]       running_sum_reg, running_sum_next;
    logic [7:0]       prev_byte_reg, prev_byte_next;
    logic [7:0]       prev_prev_byte_reg, prev_prev_byte_next;
    logic [7:0]       cur_func_reg, cur_func_next;
    logic [31:0]      cur_tag_reg, cur_tag_next;

    logic [31:0]      idx;
    logic [CNT_W:0]   total;
    logic             overflow;
    logic             len_ok;
    logic [7:0]       b;

    assign b        = beat.data_byte;
    assign idx      = 32'(byte_count_reg);
    assign total    = {1'b0, byte_count_reg} + (CNT_W+1)'(1);
    assign overflow = idx >= 32'(MAX_FRAME_LEN);
    assign len_ok   = (LEN_W'(total) - LEN_W'(FRAME_OVERHEAD)) == LEN_W'(declared_len_next);

    // Field capture and checksum for this byte.
    always_comb begin
        head_first_next   = head_first_reg;
        head_second_next  = head_second_reg;
        declared_len_next = declared_len_reg;
        cur_func_next     = cur_func_reg;
        cur_tag_next      = cur_tag_reg;
        running_sum_next  = running_sum_reg;
        // byte two back is now known to be data, not the checksum
        if (idx >= 32'd6) begin
            running_sum_next = running_sum_reg + prev_prev_byte_reg;
        end
        if (idx == 32'd0) begin
            head_first_next = b;
        end else if (idx == 32'd1) begin
            declared_len_next = {b, declared_len_reg[7:0]};
        end else if (idx == 32'd2) begin
            declared_len_next = {declared_len_reg[15:8], b};
        end else if (idx == 32'd3) begin
            head_second_next = b;
        end else if (idx == 32'd4) begin
            cur_func_next = b;
        end else if (idx <= 32'd8) begin
            cur_tag_next = {cur_tag_reg[23:0], b};
        end
        prev_prev_byte_next = prev_byte_reg;
        prev_byte_next      = b;
        if (idx <= 32'(MAX_FRAME_LEN)) begin
            byte_count_next = byte_count_reg + CNT_W'(1);
        end else begin
            byte_count_next = byte_count_reg;
        end
    end

    // Verdict, tested in priority order.
    always_comb begin
        verdict           = '0;
        verdict.func_code = cur_func_next;
        if (32'(total) < 32'(FRAME_OVERHEAD)) begin
            verdict.status = ST_TOO_SHORT;
        end else if (head_first_next != HEAD_MARK || head_second_next != HEAD_MARK) begin
            verdict.status = ST_BAD_HEAD;
        end else if (overflow || !len_ok) begin
            verdict.status = ST_BAD_LENGTH;
        end else if (b != TAIL_MARK) begin
            verdict.status = ST_BAD_TAIL;
        end else if (running_sum_next != prev_byte_reg) begin
            verdict.status = ST_BAD_CHECKSUM;
        end else if ((cur_func_next & DIR_BIT) != 8'h00) begin
            verdict.status = ST_REPLY_DIR;
        end else if (cur_func_next != ASK_FUNC) begin
            verdict.status = ST_UNKNOWN_FUNC;
        end else if (declared_len_next < 16'(MIN_ASK_LEN)) begin
            verdict.status = ST_DUP_OR_SHORT;
        end else begin
            verdict.status   = ST_DUP_OR_SHORT;
            verdict.time_tag = cur_tag_next;
            verdict.ask_full = 1'b1;
        end
    end

    // Advance on every byte; clear everything after the end byte.
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && beat.frame_end)) begin
            byte_count_reg     <= '0;
            head_first_reg     <= '0;
            head_second_reg    <= '0;
            declared_len_reg   <= '0;
            running_sum_reg    <= '0;
            prev_byte_reg      <= '0;
            prev_prev_byte_reg <= '0;
            cur_func_reg       <= '0;
            cur_tag_reg        <= '0;
        end else if (step) begin
            byte_count_reg     <= byte_count_next;
            head_first_reg     <= head_first_next;
            head_second_reg    <= head_second_next;
            declared_len_reg   <= declared_len_next;
            running_sum_reg    <= running_sum_next;
            prev_byte_reg      <= prev_byte_next;
            prev_prev_byte_reg <= prev_prev_byte_next;
            cur_func_reg       <= cur_func_next;
            cur_tag_reg        <= cur_tag_next;
        end
    end

endmodule

`default_nettype wire

### tb/sv/fcqd_scoreboard.sv
// Checker for frame_check_and_query_dedup: predicts each frame verdict and compares result beats.
`timescale 1ns / 100ps

module fcqd_scoreboard #(
    parameter int MAX_FRAME_LEN = 1024
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    input  wire                  s_ready,
    input  fcqd_pkg::in_beat_t   s_data,
    input  wire                  m_valid,
    input  wire                  m_ready,
    input  fcqd_pkg::out_beat_t  m_data,
    output int                   errors,
    output int                   waiting
);
    import fcqd_pkg::*;

    // Shadow of the frame state.
    int unsigned byte_cnt;
    logic [7:0]  head_a;
    logic [7:0]  head_b;
    logic [15:0] len_field;
    logic [7:0]  data_sum;
    logic [7:0]  last_byte;
    logic [7:0]  older_byte;
    logic [7:0]  func_seen;
    logic [31:0] tag_seen;
    logic [31:0] kept_tag;

    out_beat_t verdict_q[$];

    task automatic forget_frame();
        byte_cnt   = 0;
        head_a     = '0;
        head_b     = '0;
        len_field  = '0;
        data_sum   = '0;
        last_byte  = '0;
        older_byte = '0;
        func_seen  = '0;
        tag_seen   = '0;
    endtask

    // Advance the shadow state by one byte; queue a verdict on the end byte.
    task automatic judge_byte(input in_beat_t beat);
        int unsigned pos;
        int unsigned total;
        logic        overflow;
        out_beat_t   v;
        pos      = byte_cnt;
        overflow = (pos >= MAX_FRAME_LEN);
        total    = pos + 1;
        // the byte two back cannot be the checksum any more
        if (pos >= 6) data_sum = data_sum + older_byte;
        case (pos)
            0: head_a = beat.data_byte;
            1: len_field[15:8] = beat.data_byte;
            2: len_field[7:0] = beat.data_byte;
            3: head_b = beat.data_byte;
            4: func_seen = beat.data_byte;
            5, 6, 7, 8: tag_seen = {tag_seen[23:0], beat.data_byte};
            default: ;
        endcase
        if (!beat.frame_end) begin
            older_byte = last_byte;
            last_byte  = beat.data_byte;
            if (byte_cnt <= MAX_FRAME_LEN) byte_cnt++;
        end else begin
            v.func_code = func_seen;
            v.time_tag  = '0;
            if (total < FRAME_OVERHEAD) begin
                v.status = ST_TOO_SHORT;
            end else if (head_a != HEAD_MARK || head_b != HEAD_MARK) begin
                v.status = ST_BAD_HEAD;
            end else if (overflow || (total - FRAME_OVERHEAD) != len_field) begin
                v.status = ST_BAD_LENGTH;
            end else if (beat.data_byte != TAIL_MARK) begin
                v.status = ST_BAD_TAIL;
            end else if (data_sum != last_byte) begin
                v.status = ST_BAD_CHECKSUM;
            end else if ((func_seen & DIR_BIT) != 0) begin
                v.status = ST_REPLY_DIR;
            end else if (func_seen != ASK_FUNC) begin
                v.status = ST_UNKNOWN_FUNC;
            end else if (len_field < MIN_ASK_LEN) begin
                v.status = ST_DUP_OR_SHORT;
            end else begin
                v.time_tag = tag_seen;
                if (tag_seen == kept_tag) begin
                    v.status = ST_DUP_OR_SHORT;
                end else begin
                    kept_tag = tag_seen;
                    v.status = ST_NEW_ASK;
                end
            end
            verdict_q.push_back(v);
            forget_frame();
        end
    endtask

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            forget_frame();
            kept_tag = '0;
            verdict_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, m_data);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_data.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_data.status);
                        errors++;
                    end
                    if (m_data.func_code !== want.func_code) begin
                        $display("%0t: func_code expected %h actual %h",
                                 $time, want.func_code, m_data.func_code);
                        errors++;
                    end
                    if (m_data.time_tag !== want.time_tag) begin
                        $display("%0t: time_tag expected %h actual %h",
                                 $time, want.time_tag, m_data.time_tag);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) judge_byte(s_data);
        end
        waiting = verdict_q.size();
    end

endmodule

### tb/sv/testbench.sv
// Top of the frame_check_and_query_dedup testbench: clock, reset, frame stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import fcqd_pkg::*;

    localparam int MAX_LEN        = 1024;
    localparam int RANDOM_BEATS   = 450;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;

    // Ways of spoiling an otherwise good frame.
    typedef enum int {
        FLAW_NONE,
        FLAW_HEAD_FIRST,
        FLAW_HEAD_SECOND,
        FLAW_LENGTH,
        FLAW_TAIL,
        FLAW_CHECKSUM,
        FLAW_CUT
    } flaw_e;

    logic      aclk    = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    int errors;
    int waiting;
    int beats_sent = 0;
    int stall_cnt  = 0;
    bit steady     = 1'b0;   // set to hold off all idling on both sides

    logic [31:0] tag_pool[4];

    frame_check_and_query_dedup #(
        .MAX_FRAME_LEN(MAX_LEN)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    fcqd_scoreboard #(
        .MAX_FRAME_LEN(MAX_LEN)
    ) checker_i (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data),
        .errors (errors),
        .waiting(waiting)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: drop ready at random, with a 20 percent chance, unless a steady stretch is on.
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 20);
    end

    // Watchdog: count cycles with no beat moving on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cnt = 0;
        end else begin
            stall_cnt++;
        end
        if (stall_cnt >= WATCHDOG_LIMIT) begin
            $display("frame_check_and_query_dedup regression: fail");
            $finish;
        end
    end

    // Offer one byte beat and hold it until accepted. Entered and left at a falling edge.
    task automatic push_beat(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, frame_end: last};
        @(posedge aclk iff s_ready);
        beats_sent++;
        @(negedge aclk);
    endtask

    // Build a frame around ndata data bytes (function, big-endian tag, filler),
    // spoil it as asked, then send it with the end flag on its last byte.
    task automatic send_frame(input logic [7:0] fn, input logic [31:0] tg,
                              input int ndata, input flaw_e flaw);
        logic [7:0]  frame_q[$];
        logic [7:0]  sum;
        logic [7:0]  d;
        logic [15:0] len_word;
        int          n;
        sum      = '0;
        len_word = ndata[15:0];
        if (flaw == FLAW_LENGTH) len_word = len_word ^ (16'd1 << $urandom_range(0, 15));
        frame_q.push_back(flaw == FLAW_HEAD_FIRST ?
                          HEAD_MARK ^ 8'($urandom_range(1, 255)) : HEAD_MARK);
        frame_q.push_back(len_word[15:8]);
        frame_q.push_back(len_word[7:0]);
        frame_q.push_back(flaw == FLAW_HEAD_SECOND ?
                          HEAD_MARK ^ 8'($urandom_range(1, 255)) : HEAD_MARK);
        for (int i = 0; i < ndata; i++) begin
            if (i == 0) d = fn;
            else if (i <= 4) d = tg[8*(4-i) +: 8];
            else d = 8'($urandom);
            sum = sum + d;
            frame_q.push_back(d);
        end
        frame_q.push_back(flaw == FLAW_CHECKSUM ? sum ^ 8'($urandom_range(1, 255)) : sum);
        frame_q.push_back(flaw == FLAW_TAIL ?
                          TAIL_MARK ^ 8'($urandom_range(1, 255)) : TAIL_MARK);
        n = frame_q.size();
        if (flaw == FLAW_CUT) n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) push_beat(frame_q[i], i == n - 1);
    endtask

    // Random bytes with the end flag on the last; sometimes opened with a head mark.
    task automatic send_noise(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom);
            if (i == 0 && $urandom_range(0, 1)) b = HEAD_MARK;
            push_beat(b, i == n - 1);
        end
    endtask

    initial begin
        int    pick;
        int    ndata;
        flaw_e flaw;
        logic [31:0] tg;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        tag_pool[0] = 32'h0;
        for (int i = 1; i < 4; i++) tag_pool[i] = $urandom;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed frames: every verdict and the field extremes.
        send_noise(1);                                   // single byte, no function code
        send_frame(ASK_FUNC, 32'h1234_5678, 6, FLAW_CUT);
        send_frame(ASK_FUNC, 32'h0, 5, FLAW_HEAD_FIRST);
        send_frame(ASK_FUNC, 32'h0, 5, FLAW_HEAD_SECOND);
        send_frame(ASK_FUNC, 32'h0, 5, FLAW_LENGTH);
        send_frame(ASK_FUNC, 32'h0, 5, FLAW_TAIL);
        send_frame(ASK_FUNC, 32'h0, 5, FLAW_CHECKSUM);
        send_frame(8'h81, 32'hFFFF_FFFF, 5, FLAW_NONE);  // reply direction bit
        send_frame(8'hFF, 32'h0, 8, FLAW_NONE);
        send_frame(8'h00, 32'h0, 5, FLAW_NONE);          // unknown function
        send_frame(8'h7F, 32'h0, 3, FLAW_NONE);
        send_frame(ASK_FUNC, 32'h0, 5, FLAW_NONE);       // matches the tag left by reset
        send_frame(ASK_FUNC, 32'hFFFF_FFFF, 5, FLAW_NONE);
        send_frame(ASK_FUNC, 32'hFFFF_FFFF, 9, FLAW_NONE);
        send_frame(ASK_FUNC, 32'h0, 4, FLAW_NONE);       // short ask
        send_frame(ASK_FUNC, 32'h0, 1, FLAW_NONE);
        send_frame(ASK_FUNC, 32'h0, 0, FLAW_NONE);       // no data at all
        send_frame(ASK_FUNC, 32'h8000_0001, 30, FLAW_NONE);

        // Random frames: mostly well-formed, the rest broken frames and noise.
        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS) begin
            steady = (beats_sent >= 150 && beats_sent < 300);
            pick   = $urandom_range(0, 99);
            tg     = $urandom_range(0, 1) ? tag_pool[$urandom_range(0, 3)] : $urandom;
            ndata  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12);
            if (pick < 55) begin
                send_frame(ASK_FUNC, tg, ndata, FLAW_NONE);
            end else if (pick < 70) begin
                send_frame(8'($urandom), tg, ndata, FLAW_NONE);
            end else if (pick < 88) begin
                flaw = flaw_e'($urandom_range(FLAW_HEAD_FIRST, FLAW_CUT));
                send_frame(ASK_FUNC, tg, ndata, flaw);
            end else begin
                send_noise($urandom_range(1, 20));
            end
        end
        steady  = 1'b0;
        s_valid <= 1'b0;

        // Drain: wait for every verdict, then wait on for any stray beat.
        while (waiting != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (errors == 0 && waiting == 0) begin
            $display("frame_check_and_query_dedup regression: pass");
        end else begin
            $display("frame_check_and_query_dedup regression: fail");
        end
        $finish;
    end

endmodule
